>>> sv/gte_pkg.sv
// ----------------------------------------------------------------------------
// Graph traversal engine package
// Shared sizes, codes and the command/status structs between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gte_pkg;

  // Storage sizes.
  localparam int MaxNodes   = 64;
  localparam int MaxAdj     = 1024;
  localparam int NodeW      = $clog2(MaxNodes);
  localparam int CntW       = $clog2(MaxNodes + 1);
  localparam int AdjW       = $clog2(MaxAdj);
  localparam int UsedW      = AdjW + 1;
  localparam int NodeCountW = 7;

  // An edge needs two free entries; beyond this fill level it is dropped.
  localparam logic [UsedW-1:0] EdgesUsedMax = UsedW'(MaxAdj - 2);

  // Configuration port.
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = NodeCountW;
  localparam logic [CfgIdxW-1:0] CfgNodeCount = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgWalkMode  = 1'b1;

  // Input item kinds and walk modes.
  localparam logic KindAddEdge  = 1'b0;
  localparam logic KindTraverse = 1'b1;
  localparam logic WalkFifo     = 1'b0;

  // Stream widths.
  localparam int InDataW  = 16;
  localparam int OutDataW = 8;

  // Read address source of the list head/tail store.
  typedef enum logic [1:0] {
    HT_IN_A,
    HT_B,
    HT_NODE
  } ht_sel_e;

  typedef struct packed {
    logic [AdjW-1:0] head;
    logic [AdjW-1:0] tail;
  } ht_entry_t;

  typedef struct packed {
    logic    load_item;
    logic    edge_drop;
    ht_sel_e ht_sel;
    logic    write_a;
    logic    write_b;
    logic    trav_clear;
    logic    trav_seed;
    logic    pop;
    logic    latch_node;
    logic    edge_rd_head;
    logic    visit;
    logic    emit;
  } gte_cmd_t;

  typedef struct packed {
    logic in_kind;
    logic in_drop;
    logic src_ok;
    logic list_valid;
    logic at_tail;
    logic is_last;
    logic out_free;
  } gte_sts_t;

endpackage

`default_nettype wire

>>> sv/gte_ctrl.sv
// ----------------------------------------------------------------------------
// Graph traversal engine controller
// Sequences edge appends and the pop / list walk / emit loop of a traversal.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_ctrl
  import gte_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_valid_i,
  output logic          s_ready_o,
  input  wire gte_sts_t sts_i,
  output gte_cmd_t      cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWrA   = 3'd1;
  localparam logic [2:0] StWrB   = 3'd2;
  localparam logic [2:0] StPop   = 3'd3;
  localparam logic [2:0] StFetch = 3'd4;
  localparam logic [2:0] StHead  = 3'd5;
  localparam logic [2:0] StNb    = 3'd6;
  localparam logic [2:0] StEmit  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.ht_sel = HT_IN_A;
    s_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (sts_i.in_kind == KindAddEdge) begin
            if (sts_i.in_drop) begin
              cmd_o.edge_drop = 1'b1;
            end else begin
              state_d = StWrA;
            end
          end else begin
            cmd_o.trav_clear = 1'b1;
            if (sts_i.src_ok) begin
              cmd_o.trav_seed = 1'b1;
              state_d = StPop;
            end
          end
        end
      end
      StWrA: begin
        cmd_o.write_a = 1'b1;
        cmd_o.ht_sel  = HT_B;
        state_d = StWrB;
      end
      StWrB: begin
        cmd_o.write_b = 1'b1;
        state_d = StIdle;
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d = StFetch;
      end
      StFetch: begin
        cmd_o.latch_node = 1'b1;
        cmd_o.ht_sel     = HT_NODE;
        state_d = StHead;
      end
      StHead: begin
        if (sts_i.list_valid) begin
          cmd_o.edge_rd_head = 1'b1;
          state_d = StNb;
        end else begin
          state_d = StEmit;
        end
      end
      StNb: begin
        cmd_o.visit = 1'b1;
        if (sts_i.at_tail) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = sts_i.is_last ? StIdle : StPop;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/gte_dpath.sv
// ----------------------------------------------------------------------------
// Graph traversal engine datapath
// Adjacency store, list head/tail store, visited map, work list and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gte_dpath
  import gte_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [InDataW-1:0]    s_data_i,
  input  wire logic                  s_user_i,
  input  wire logic [NodeCountW-1:0] node_count_i,
  input  wire logic                  walk_mode_i,
  input  wire gte_cmd_t              cmd_i,
  output gte_sts_t                   sts_o,
  input  wire logic                  m_ready_i,
  output logic                       m_valid_o,
  output logic [NodeW-1:0]           m_node_o,
  output logic                       m_last_o,
  output logic                       m_ovf_o
);

  // Input fields and effective node count.
  logic [NodeW-1:0]      in_a, in_b;
  logic [NodeCountW-1:0] nc;

  assign in_a = s_data_i[NodeW-1:0];
  assign in_b = s_data_i[2*NodeW-1:NodeW];
  assign nc   = (node_count_i > NodeCountW'(MaxNodes)) ? NodeCountW'(MaxNodes)
                                                       : node_count_i;

  // Edge loading state.
  logic [NodeW-1:0]     a_q, b_q;
  logic [UsedW-1:0]     edges_used_q, edges_used_d;
  logic                 dropped_q;
  logic [MaxNodes-1:0]  ht_valid_q, ht_valid_d;
  ht_entry_t            ht_mem [MaxNodes];
  ht_entry_t            ht_rd_q, ht_wr_q;
  logic [NodeW-1:0]     ht_raddr;
  logic [NodeW-1:0]     owner;
  logic                 owner_valid;
  ht_entry_t            owner_src;
  ht_entry_t            ht_wdata;
  logic                 ht_we;
  logic [AdjW-1:0]      slot;
  logic [NodeW-1:0]     tgt_wdata;

  // Adjacency store.
  logic [NodeW-1:0]     tgt_mem [MaxAdj];
  logic [AdjW-1:0]      lnk_mem [MaxAdj];
  logic [NodeW-1:0]     tgt_rd_q;
  logic [AdjW-1:0]      lnk_rd_q;
  logic [AdjW-1:0]      edge_raddr;
  logic [AdjW-1:0]      e_q, tail_q;

  // Traversal state.
  logic [MaxNodes-1:0]  visited_q, visited_d;
  logic [NodeW-1:0]     work_mem [MaxNodes];
  logic [NodeW-1:0]     work_rd_q;
  logic [CntW-1:0]      rd_q, rd_d, wr_q, wr_d, cnt_q, cnt_d;
  logic [CntW-1:0]      wr_dec;
  logic [NodeW-1:0]     pop_idx;
  logic [NodeW-1:0]     node_q;
  logic                 push_ok;
  logic                 work_we;
  logic [NodeW-1:0]     work_waddr, work_wdata;

  // Output register.
  logic                 out_valid_q, out_valid_d;
  logic [NodeW-1:0]     out_node_q;
  logic                 out_last_q, out_ovf_q;

  // ---------------------------------------------------------------- status
  always_comb begin
    sts_o.in_kind    = s_user_i;
    sts_o.in_drop    = (NodeCountW'(in_a) >= nc) || (NodeCountW'(in_b) >= nc) ||
                       (edges_used_q > EdgesUsedMax);
    sts_o.src_ok     = NodeCountW'(in_a) < nc;
    sts_o.list_valid = ht_valid_q[node_q];
    sts_o.at_tail    = (e_q == tail_q);
    sts_o.is_last    = (rd_q == wr_q) || (cnt_q == CntW'(MaxNodes - 1));
    sts_o.out_free   = !out_valid_q || m_ready_i;
  end

  // -------------------------------------------------------------- appends
  always_comb begin
    unique case (cmd_i.ht_sel)
      HT_IN_A: ht_raddr = in_a;
      HT_B:    ht_raddr = b_q;
      HT_NODE: ht_raddr = work_rd_q;
      default: ht_raddr = in_a;
    endcase
  end

  assign ht_we       = cmd_i.write_a || cmd_i.write_b;
  assign owner       = cmd_i.write_a ? a_q : b_q;
  assign tgt_wdata   = cmd_i.write_a ? b_q : a_q;
  assign owner_valid = ht_valid_q[owner];
  assign slot        = edges_used_q[AdjW-1:0];
  // A self loop reads the entry just written for the first endpoint.
  assign owner_src   = (cmd_i.write_b && (a_q == b_q)) ? ht_wr_q : ht_rd_q;

  always_comb begin
    ht_wdata.head = owner_valid ? owner_src.head : slot;
    ht_wdata.tail = slot;
  end

  always_comb begin
    edges_used_d = edges_used_q;
    ht_valid_d   = ht_valid_q;
    if (ht_we) begin
      edges_used_d      = edges_used_q + UsedW'(1);
      ht_valid_d[owner] = 1'b1;
    end
  end

  // ------------------------------------------------------------ list walk
  assign edge_raddr = cmd_i.edge_rd_head ? ht_rd_q.head : lnk_rd_q;
  assign push_ok    = cmd_i.visit && (NodeCountW'(tgt_rd_q) < nc) &&
                      !visited_q[tgt_rd_q] && (wr_q < CntW'(MaxNodes));
  assign wr_dec     = wr_q - CntW'(1);
  assign pop_idx    = (walk_mode_i == WalkFifo) ? rd_q[NodeW-1:0] : wr_dec[NodeW-1:0];

  always_comb begin
    rd_d       = rd_q;
    wr_d       = wr_q;
    cnt_d      = cnt_q;
    visited_d  = visited_q;
    work_we    = 1'b0;
    work_waddr = wr_q[NodeW-1:0];
    work_wdata = tgt_rd_q;
    if (cmd_i.trav_clear) begin
      visited_d = '0;
    end
    if (cmd_i.trav_seed) begin
      visited_d[in_a] = 1'b1;
      rd_d       = '0;
      wr_d       = CntW'(1);
      cnt_d      = '0;
      work_we    = 1'b1;
      work_waddr = '0;
      work_wdata = in_a;
    end
    if (cmd_i.pop) begin
      if (walk_mode_i == WalkFifo) begin
        rd_d = rd_q + CntW'(1);
      end else begin
        wr_d = wr_dec;
      end
    end
    if (push_ok) begin
      visited_d[tgt_rd_q] = 1'b1;
      wr_d    = wr_q + CntW'(1);
      work_we = 1'b1;
    end
    if (cmd_i.emit) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ------------------------------------------------------ control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edges_used_q <= '0;
      dropped_q    <= 1'b0;
      ht_valid_q   <= '0;
      visited_q    <= '0;
      rd_q         <= '0;
      wr_q         <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      edges_used_q <= edges_used_d;
      if (cmd_i.edge_drop) begin
        dropped_q <= 1'b1;
      end
      ht_valid_q   <= ht_valid_d;
      visited_q    <= visited_d;
      rd_q         <= rd_d;
      wr_q         <= wr_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // ------------------------------------------------------ payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      a_q <= in_a;
      b_q <= in_b;
    end
    if (cmd_i.write_a) begin
      ht_wr_q <= ht_wdata;
    end
    if (cmd_i.latch_node) begin
      node_q <= work_rd_q;
    end
    if (cmd_i.edge_rd_head) begin
      tail_q <= ht_rd_q.tail;
    end
    e_q <= edge_raddr;
    if (cmd_i.emit) begin
      out_node_q <= node_q;
      out_last_q <= sts_o.is_last;
      out_ovf_q  <= dropped_q;
    end
  end

  // -------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (ht_we) begin
      ht_mem[owner] <= ht_wdata;
    end
    ht_rd_q <= ht_mem[ht_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ht_we) begin
      tgt_mem[slot] <= tgt_wdata;
    end
    tgt_rd_q <= tgt_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ht_we && owner_valid) begin
      lnk_mem[owner_src.tail] <= slot;
    end
    lnk_rd_q <= lnk_mem[edge_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd_q <= work_mem[pop_idx];
  end

  assign m_valid_o = out_valid_q;
  assign m_node_o  = out_node_q;
  assign m_last_o  = out_last_q;
  assign m_ovf_o   = out_ovf_q;

endmodule

`default_nettype wire

>>> sv/graph_traversal_engine.sv
// ----------------------------------------------------------------------------
// Graph traversal engine
// Stores an undirected graph as per-node adjacency lists and walks it from a
// source node, breadth first (FIFO work list) or with a stack work list.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  -------  ---------  ------------------------------------------------------
//  s_axis   in         tdata: node_a[5:0], node_b[11:6]; tuser: kind
//  m_axis   out        tdata: visited_node[5:0]; tlast: last_node;
//                      tuser: overflow
//  cfg      in         cfg_index_i selects node_count (0) or walk_mode (1)
//
//  An add-edge beat is taken in an accept cycle that reads the first
//  endpoint's list head/tail entry, then each endpoint gets its own append step.
//  A dropped edge only sets the overflow flag. A traversal seeds the work
//  list in its accept cycle, then steps each visited node through pop, fetch,
//  head and emit, with a neighbor step for each stored neighbor entry.
//  A full output register stalls the walk at the emit step only; rst_ni
//  clears the lists, the visited map and the overflow flag at once.
//
`default_nettype none

module graph_traversal_engine
  import gte_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  // Input items.
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,   // node_a, node_b, zero pad
  input  wire logic                s_axis_tuser_i,   // kind

  // Result items.
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OutDataW-1:0]      m_axis_tdata_o,   // visited_node, zero pad
  output logic                     m_axis_tlast_o,   // last_node
  output logic                     m_axis_tuser_o,   // overflow

  // Configuration writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers take every write. The user must send writes only
  // while the engine is idle (not enforced), so no item sees a register change.
  logic [NodeCountW-1:0] node_count_q;
  logic                  walk_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountW'(64);
      walk_mode_q  <= WalkFifo;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgNodeCount: node_count_q <= cfg_data_i[NodeCountW-1:0];
        CfgWalkMode:  walk_mode_q  <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  gte_cmd_t         cmd;
  gte_sts_t         sts;
  logic [NodeW-1:0] out_node;

  // The controller sequences the appends and the pop / walk / emit loop.
  gte_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // The datapath holds all stores and the output register.
  gte_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_data_i     (s_axis_tdata_i),
    .s_user_i     (s_axis_tuser_i),
    .node_count_i (node_count_q),
    .walk_mode_i  (walk_mode_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .m_ready_i    (m_axis_tready_i),
    .m_valid_o    (m_axis_tvalid_o),
    .m_node_o     (out_node),
    .m_last_o     (m_axis_tlast_o),
    .m_ovf_o      (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(OutDataW - NodeW){1'b0}}, out_node};

  // ------------------------------------------------------------ assertions

  // A result is only loaded into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded into a busy output register");

  // The first append is always followed by the second endpoint's append.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.write_a |=> cmd.write_b)
    else $error("edge append left half done");

  // A traversal from an unused source gives nothing and frees the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == KindTraverse) &&
     !sts.src_ok) |=> s_axis_tready_o)
    else $error("traversal from an unused source did not return to idle");

  // The overflow flag is sticky across consecutive result beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && $past(m_axis_tvalid_o) && $past(m_axis_tuser_o))
      |-> m_axis_tuser_o)
    else $error("overflow flag fell");

endmodule

`default_nettype wire

>>> tb/tb_graph_traversal_engine.sv
// ----------------------------------------------------------------------------
// Graph traversal engine testbench
// Loads undirected edges into the engine and walks the graph from chosen
// source nodes in both work-list orders. A predictor keeps its own copy of
// the adjacency lists and of the configuration, computes the node order that
// each walk must produce, and every result beat is checked against it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_graph_traversal_engine;
  import gte_pkg::*;

  // The longest quiet stretch of a correct run is the settle pause below, or a
  // walk scanning a long adjacency list between two emits. Both stay far
  // below this many cycles without any accepted beat.
  localparam int unsigned StallLimit = 20000;
  // Config writes wait this long once every expected result has arrived, which
  // covers the endpoint appends that trail the last accepted edge.
  localparam int unsigned SettleCycles = 16;
  localparam logic WalkStack = ~WalkFifo;

  typedef struct packed {
    logic             kind;
    logic [NodeW-1:0] node_a;
    logic [NodeW-1:0] node_b;
  } graph_cmd_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic             last;
    logic             ovf;
  } visit_t;

  // DUT connections; everything the testbench drives starts at a known value.
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tuser_o;
  logic                cfg_valid_i     = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i      = '0;

  graph_traversal_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the graph, the sticky drop flag and
  // the two configuration registers as last written.
  // --------------------------------------------------------------------------
  logic [NodeW-1:0]      adj_entry [MaxNodes][MaxAdj];
  int unsigned           adj_len   [MaxNodes];
  int unsigned           entries_used  = 0;
  logic                  edge_dropped  = 1'b0;
  logic [NodeCountW-1:0] node_count_cfg = NodeCountW'(MaxNodes);
  logic                  walk_cfg       = WalkFifo;

  visit_t     visit_order_q [$];   // node visits still owed by the engine
  graph_cmd_t pending_q [$];       // items waiting for the driver

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned walks_started  = 0;
  int unsigned edges_lost     = 0;
  int unsigned visits_checked = 0;
  int unsigned errors         = 0;

  initial begin
    foreach (adj_len[i]) adj_len[i] = 0;
  end

  // A node count above the node capacity behaves as the full capacity.
  function automatic int unsigned active_nodes();
    return (node_count_cfg > MaxNodes) ? MaxNodes : int'(node_count_cfg);
  endfunction

  // An edge lands in both endpoint lists, or is dropped as a whole when an
  // endpoint is out of range or fewer than two store entries are left.
  function automatic void load_edge(input logic [NodeW-1:0] a, input logic [NodeW-1:0] b);
    int unsigned nc;
    nc = active_nodes();
    if (a >= nc || b >= nc || MaxAdj - entries_used < 2) begin
      edge_dropped = 1'b1;
      edges_lost++;
      return;
    end
    adj_entry[a][adj_len[a]] = b;
    adj_len[a]++;
    adj_entry[b][adj_len[b]] = a;
    adj_len[b]++;
    entries_used += 2;
  endfunction

  // Walks from src and appends the visit order to the expected results.
  // Neighbors are marked when pushed, so in stack order a node is never
  // pushed twice even though that differs from a textbook depth-first walk.
  function automatic void walk_graph(input logic [NodeW-1:0] src);
    int unsigned      nc;
    int unsigned      rd;
    int unsigned      wr;
    int unsigned      count;
    bit               seen  [MaxNodes];
    logic [NodeW-1:0] work  [MaxNodes];
    logic [NodeW-1:0] order [MaxNodes];
    logic [NodeW-1:0] node;
    logic [NodeW-1:0] nb;
    visit_t           v;
    nc    = active_nodes();
    rd    = 0;
    wr    = 0;
    count = 0;
    foreach (seen[i]) seen[i] = 1'b0;
    // The visited map is cleared even when the source is rejected.
    if (src >= nc) return;
    seen[src] = 1'b1;
    work[wr]  = src;
    wr++;
    while (rd < wr && count < MaxNodes) begin
      if (walk_cfg == WalkFifo) begin
        node = work[rd];
        rd++;
      end else begin
        wr--;
        node = work[wr];
      end
      order[count] = node;
      count++;
      for (int k = 0; k < adj_len[node]; k++) begin
        nb = adj_entry[node][k];
        // Neighbors stored before the node count was lowered are skipped.
        if (nb < nc && !seen[nb] && wr < MaxNodes) begin
          seen[nb] = 1'b1;
          work[wr] = nb;
          wr++;
        end
      end
    end
    for (int i = 0; i < count; i++) begin
      v.node = order[i];
      v.last = (i == count - 1);
      v.ovf  = edge_dropped;
      visit_order_q = {visit_order_q, v};
    end
  endfunction

  // Per-beat wait: a random wait, or none during occasional runs of back-to-back beats.
  function automatic int unsigned draw_wait(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm_left = $urandom_range(5, 25);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: takes items from pending_q, idles a random number of cycles
  // before each one, and feeds the predictor on every accepted beat.
  // --------------------------------------------------------------------------
  graph_cmd_t  cur_item;
  int unsigned send_wait = 0;
  int unsigned send_calm = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      send_wait = draw_wait(send_calm);
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        items_accepted++;
        if (cur_item.kind == KindTraverse) begin
          walks_started++;
          walk_graph(cur_item.node_a);
        end else begin
          load_edge(cur_item.node_a, cur_item.node_b);
        end
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_wait > 0) begin
          send_wait--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_item = pending_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= cur_item.kind;
          s_axis_tdata_i  <= {{(InDataW - 2 * NodeW){1'b0}}, cur_item.node_b, cur_item.node_a};
          send_wait = draw_wait(send_calm);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: stalls a random number of cycles after each beat and
  // checks every accepted beat against the oldest expected visit.
  // --------------------------------------------------------------------------
  visit_t      want;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (visit_order_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat, expected none, actual node %0d last %0b ovf %0b",
                   $time, m_axis_tdata_o[NodeW-1:0], m_axis_tlast_o, m_axis_tuser_o);
        end else begin
          want = visit_order_q.pop_front();
          visits_checked++;
          if (m_axis_tdata_o[NodeW-1:0] !== want.node) begin
            errors++;
            $display("%0t: visited_node expected %0d actual %0d",
                     $time, want.node, m_axis_tdata_o[NodeW-1:0]);
          end
          if (m_axis_tlast_o !== want.last) begin
            errors++;
            $display("%0t: last_node expected %0b actual %0b", $time, want.last, m_axis_tlast_o);
          end
          if (m_axis_tuser_o !== want.ovf) begin
            errors++;
            $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, m_axis_tuser_o);
          end
        end
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no beat is accepted on any channel for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
        $display("%0t: no beat accepted for %0d cycles, %0d visits still expected",
                 $time, StallLimit, visit_order_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequencing.
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic kind, input logic [NodeW-1:0] a,
                            input logic [NodeW-1:0] b);
    graph_cmd_t c;
    c.kind   = kind;
    c.node_a = a;
    c.node_b = b;
    pending_q = {pending_q, c};
    items_queued++;
  endtask

  // Waits until every queued item is taken and every expected visit has come;
  // with linger set, also lets the trailing edge appends finish.
  task automatic settle(input bit linger);
    while (items_accepted != items_queued || visit_order_q.size() != 0) @(posedge clk_i);
    if (linger) repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgNodeCount) node_count_cfg = val;
    else walk_cfg = val[0];
  endtask

  // Mostly in-range edges so the lists grow; the rest are stray endpoints.
  task automatic queue_random(input int unsigned nc);
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
    if (nc > 0 && $urandom_range(0, 9) != 0) begin
      a = NodeW'($urandom_range(0, nc - 1));
      b = NodeW'($urandom_range(0, nc - 1));
    end else begin
      a = NodeW'($urandom_range(0, MaxNodes - 1));
      b = NodeW'($urandom_range(0, MaxNodes - 1));
    end
    if ($urandom_range(0, 3) == 0) begin
      queue_item(KindTraverse, a, NodeW'($urandom_range(0, MaxNodes - 1)));
    end else begin
      queue_item(KindAddEdge, a, b);
    end
  endtask

  initial begin
    int unsigned      nc_pick;
    int unsigned      edges_to_fill;
    logic [NodeW-1:0] src;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full node range, breadth order: lone source, extreme node numbers, a
    // self loop and alternating bit patterns.
    write_reg(CfgNodeCount, NodeCountW'(MaxNodes));
    write_reg(CfgWalkMode, {{(CfgDataW - 1){1'b0}}, WalkFifo});
    queue_item(KindTraverse, 6'd5, 6'd63);
    queue_item(KindAddEdge, 6'd0, 6'd63);
    queue_item(KindAddEdge, 6'd63, 6'd1);
    queue_item(KindAddEdge, 6'd1, 6'd1);
    queue_item(KindAddEdge, 6'd0, 6'd2);
    queue_item(KindAddEdge, 6'd2, 6'd63);
    queue_item(KindAddEdge, 6'd42, 6'd21);
    queue_item(KindAddEdge, 6'd21, 6'd0);
    queue_item(KindTraverse, 6'd0, 6'd0);
    queue_item(KindTraverse, 6'd63, 6'd42);
    settle(1'b1);

    // Node count lowered below loaded neighbors, stack order: rejected
    // endpoints raise the overflow flag, a rejected source gives nothing.
    write_reg(CfgNodeCount, 7'd3);
    write_reg(CfgWalkMode, {{(CfgDataW - 1){1'b0}}, WalkStack});
    queue_item(KindAddEdge, 6'd3, 6'd7);
    queue_item(KindAddEdge, 6'd1, 6'd63);
    queue_item(KindTraverse, 6'd0, 6'd21);
    queue_item(KindTraverse, 6'd9, 6'd0);
    queue_item(KindTraverse, 6'd1, 6'd0);
    queue_item(KindAddEdge, 6'd2, 6'd1);
    queue_item(KindTraverse, 6'd2, 6'd0);
    settle(1'b1);

    // No nodes in use: every edge dropped, every walk empty.
    write_reg(CfgNodeCount, 7'd0);
    write_reg(CfgWalkMode, {{(CfgDataW - 1){1'b0}}, WalkFifo});
    queue_item(KindAddEdge, 6'd0, 6'd0);
    queue_item(KindTraverse, 6'd0, 6'd0);
    settle(1'b1);

    // Node count beyond capacity acts as the full range.
    write_reg(CfgNodeCount, 7'd127);
    write_reg(CfgWalkMode, 7'h7F);
    queue_item(KindTraverse, 6'd0, 6'd0);
    queue_item(KindTraverse, 6'd63, 6'd0);
    queue_item(KindAddEdge, 6'd63, 6'd63);
    queue_item(KindTraverse, 6'd21, 6'd0);
    settle(1'b1);

    // Random phases, each with its own node count and walk order. Halfway
    // through each one the sender holds off until the engine has caught up.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: nc_pick = MaxNodes;
        1: nc_pick = $urandom_range(2, 16);
        2: nc_pick = 127;
        3: nc_pick = 1;
        4: nc_pick = $urandom_range(17, 63);
        default: nc_pick = $urandom_range(65, 126);
      endcase
      write_reg(CfgNodeCount, NodeCountW'(nc_pick));
      write_reg(CfgWalkMode, {CfgDataW'($urandom_range(0, 63)) << 1} | CfgDataW'(p % 2));
      for (int i = 0; i < 30; i++) begin
        if (i == 15) settle(1'b0);
        queue_random(active_nodes());
      end
      settle(1'b1);
    end

    // A last batch of edges over the full node range, then walk the denser
    // graph in both orders.
    write_reg(CfgNodeCount, NodeCountW'(MaxNodes));
    write_reg(CfgWalkMode, {{(CfgDataW - 1){1'b0}}, WalkFifo});
    edges_to_fill = 12;
    for (int i = 0; i < edges_to_fill; i++) begin
      queue_item(KindAddEdge, NodeW'($urandom_range(0, MaxNodes - 1)),
                 NodeW'($urandom_range(0, MaxNodes - 1)));
    end
    src = NodeW'($urandom_range(0, MaxNodes - 1));
    queue_item(KindTraverse, src, 6'd0);
    queue_item(KindTraverse, NodeW'($urandom_range(0, MaxNodes - 1)), 6'd63);
    settle(1'b1);
    write_reg(CfgWalkMode, {{(CfgDataW - 1){1'b0}}, WalkStack});
    queue_item(KindTraverse, src, 6'd0);
    queue_item(KindTraverse, NodeW'($urandom_range(0, MaxNodes - 1)), 6'd0);
    settle(1'b1);

    $display("Run covered %0d items (%0d walks), %0d node visits checked.",
             items_accepted, walks_started, visits_checked);
    $display("Edge store ended with %0d of %0d entries used, %0d edges dropped, %0d errors.",
             entries_used, MaxAdj, edges_lost, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
